FILE: sv/pfc_pkg.sv
// Shared types, constants and helper functions for the Playfair digram cipher core.
// No dependencies; compiled first.
package pfc_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;
  typedef logic [1:0] opcode_t;

  // Item opcodes
  localparam opcode_t OP_CLEAR  = 2'd0;
  localparam opcode_t OP_KEY    = 2'd1;
  localparam opcode_t OP_FINISH = 2'd2;
  localparam opcode_t OP_PAIR   = 2'd3;

  // Square geometry and alphabet
  localparam int      ALPHA_N     = 26;
  localparam int      CELLS_N     = 25;
  localparam letter_t ALPHA       = 5'd26;
  localparam letter_t SQ_CELLS    = 5'd25;
  localparam letter_t LAST_CELL   = 5'd24;
  localparam letter_t LAST_LETTER = 5'd25;
  localparam letter_t CODE_I      = 5'd8;
  localparam letter_t CODE_J      = 5'd9;
  localparam coord_t  LAST_COORD  = 3'd4;

  // Treat j as i
  function automatic letter_t fold_j(input letter_t c);
    return (c == CODE_J) ? CODE_I : c;
  endfunction

  // Step a row or column index by one with wrap
  function automatic coord_t wrap_inc(input coord_t v);
    return (v == LAST_COORD) ? 3'd0 : v + 3'd1;
  endfunction

  // Row-major cell address: row * 5 + col
  function automatic letter_t cell_addr(input coord_t row, input coord_t col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

FILE: sv/pfc_in_if.sv
// Input channel of the Playfair core: valid/ready handshake plus one item.
// Depends on pfc_pkg.
interface pfc_in_if;
  logic              valid;
  logic              ready;
  pfc_pkg::opcode_t  opcode;
  pfc_pkg::letter_t  letter_a;
  pfc_pkg::letter_t  letter_b;

  modport source (output valid, output opcode, output letter_a, output letter_b,
                  input ready);
  modport sink   (input valid, input opcode, input letter_a, input letter_b,
                  output ready);
endinterface

FILE: sv/pfc_out_if.sv
// Result channel of the Playfair core: valid/ready handshake plus one item.
// Depends on pfc_pkg.
interface pfc_out_if;
  logic              valid;
  logic              ready;
  pfc_pkg::letter_t  cipher_a;
  pfc_pkg::letter_t  cipher_b;
  logic              square_full;

  modport source (output valid, output cipher_a, output cipher_b, output square_full,
                  input ready);
  modport sink   (input valid, input cipher_a, input cipher_b, input square_full,
                  output ready);
endinterface

FILE: sv/pfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/playfair_digram_cipher_core.sv
// Playfair 5x5 key square builder and digram encryptor. Every item gives exactly one
// result item. A clear item, a key-letter item, or a pair item on a partial square or with
// a code past z goes straight to the done state, where its result is registered. A finish
// item walks the alphabet (one alphabet letter per cycle) and a full pair item searches
// the square: it sits in a 25-entry RAM with one read port, and a walk cell by cell
// compares each cell read against both letters before two more reads fetch the cipher
// letters. The input is ready only while the sequencer is idle, which it is again from
// the cycle in which the result is registered. A finished result waits in the output
// register and the next item is taken meanwhile; a result that is still waiting when the
// next one is done holds the sequencer until it leaves. Depends on pfc_pkg, pfc_in_if,
// pfc_out_if and pfc_ram.
module playfair_digram_cipher_core (
  input  logic           clk,
  input  logic           rst_n,
  pfc_in_if.sink         in_ch,
  pfc_out_if.source      out_ch
);
  import pfc_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIN  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_Q1   = 3'd4;
  localparam logic [2:0] S_Q2   = 3'd5;
  localparam logic [2:0] S_Q3   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]         state_r, state_nxt;
  letter_t            fill_r, fill_nxt;
  logic [ALPHA_N-1:0] used_r, used_nxt;
  letter_t            let_r, let_nxt;
  letter_t            addr_r, addr_nxt;
  coord_t             row_r, row_nxt, col_r, col_nxt;
  coord_t             prow_r, prow_nxt, pcol_r, pcol_nxt;
  logic               chk_r, chk_nxt;
  letter_t            ta_r, ta_nxt, tb_r, tb_nxt;
  coord_t             r1_r, r1_nxt, c1_r, c1_nxt, r2_r, r2_nxt, c2_r, c2_nxt;
  letter_t            ca_r, ca_nxt, cb_r, cb_nxt;
  logic               out_valid_r, out_valid_nxt;
  letter_t            out_ca_r, out_ca_nxt, out_cb_r, out_cb_nxt;
  logic               out_full_r, out_full_nxt;

  logic    accept;
  letter_t ap_c;
  logic    ap_req, ap_hit, ap_ok;
  letter_t raddr, rdata;
  coord_t  q1r, q1c, q2r, q2c;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Append path shared by key letters and the finish walk
  assign ap_c   = (state_r == S_FIN) ? let_r : fold_j(in_ch.letter_a);
  assign ap_req = ((state_r == S_FIN) && (let_r != CODE_J)) ||
                  (accept && (in_ch.opcode == OP_KEY));
  assign ap_hit = (ap_c < ALPHA) ? used_r[ap_c] : 1'b1;
  assign ap_ok  = ap_req && !ap_hit && (fill_r < SQ_CELLS);

  // Cipher cell coordinates from the located pair
  always_comb begin
    if (r1_r == r2_r) begin
      q1r = r1_r;           q1c = wrap_inc(c1_r);
      q2r = r2_r;           q2c = wrap_inc(c2_r);
    end else if (c1_r == c2_r) begin
      q1r = wrap_inc(r1_r); q1c = c1_r;
      q2r = wrap_inc(r2_r); q2c = c2_r;
    end else begin
      q1r = r1_r;           q1c = c2_r;
      q2r = r2_r;           q2c = c1_r;
    end
  end

  // Select the read address
  always_comb begin
    case (state_r)
      S_Q1:    raddr = cell_addr(q1r, q1c);
      S_Q2:    raddr = cell_addr(q2r, q2c);
      default: raddr = addr_r;
    endcase
  end

  pfc_ram #(
    .WIDTH ($bits(letter_t)),
    .DEPTH (CELLS_N)
  ) u_square (
    .clk   (clk),
    .we    (ap_ok),
    .waddr (fill_r),
    .wdata (ap_c),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    used_nxt      = used_r;
    let_nxt       = let_r;
    addr_nxt      = addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    prow_nxt      = prow_r;
    pcol_nxt      = pcol_r;
    chk_nxt       = chk_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    r1_nxt        = r1_r;
    c1_nxt        = c1_r;
    r2_nxt        = r2_r;
    c2_nxt        = c2_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ca_nxt    = out_ca_r;
    out_cb_nxt    = out_cb_r;
    out_full_nxt  = out_full_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ca_nxt = '0;
          cb_nxt = '0;
          case (in_ch.opcode)
            OP_CLEAR: begin
              used_nxt  = '0;
              fill_nxt  = '0;
              state_nxt = S_DONE;
            end
            OP_KEY: begin
              state_nxt = S_DONE;
            end
            OP_FINISH: begin
              let_nxt   = '0;
              state_nxt = S_FIN;
            end
            OP_PAIR: begin
              if ((fill_r == SQ_CELLS) && (in_ch.letter_a < ALPHA) &&
                  (in_ch.letter_b < ALPHA)) begin
                ta_nxt    = fold_j(in_ch.letter_a);
                tb_nxt    = fold_j(in_ch.letter_b);
                addr_nxt  = '0;
                row_nxt   = '0;
                col_nxt   = '0;
                chk_nxt   = 1'b0;
                state_nxt = S_SCAN;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FIN: begin
        let_nxt = let_r + 5'd1;
        if (let_r == LAST_LETTER) begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        prow_nxt = row_r;
        pcol_nxt = col_r;
        chk_nxt  = 1'b1;
        addr_nxt = addr_r + 5'd1;
        col_nxt  = wrap_inc(col_r);
        if (col_r == LAST_COORD) begin
          row_nxt = row_r + 3'd1;
        end
        if (addr_r == LAST_CELL) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        chk_nxt   = 1'b0;
        state_nxt = S_Q1;
      end
      S_Q1: begin
        state_nxt = S_Q2;
      end
      S_Q2: begin
        ca_nxt    = rdata;
        state_nxt = S_Q3;
      end
      S_Q3: begin
        cb_nxt    = rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ca_nxt    = ca_r;
          out_cb_nxt    = cb_r;
          out_full_nxt  = (fill_r == SQ_CELLS);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Compare the cell read last cycle against both targets
    if (chk_r && ((state_r == S_SCAN) || (state_r == S_TAIL))) begin
      if (rdata == ta_r) begin
        r1_nxt = prow_r;
        c1_nxt = pcol_r;
      end
      if (rdata == tb_r) begin
        r2_nxt = prow_r;
        c2_nxt = pcol_r;
      end
    end

    // Record an appended letter
    if (ap_ok) begin
      used_nxt[ap_c] = 1'b1;
      fill_nxt       = fill_r + 5'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      chk_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      chk_r       <= chk_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    let_r    <= let_nxt;
    addr_r   <= addr_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    prow_r   <= prow_nxt;
    pcol_r   <= pcol_nxt;
    ta_r     <= ta_nxt;
    tb_r     <= tb_nxt;
    r1_r     <= r1_nxt;
    c1_r     <= c1_nxt;
    r2_r     <= r2_nxt;
    c2_r     <= c2_nxt;
    ca_r     <= ca_nxt;
    cb_r     <= cb_nxt;
    out_ca_r <= out_ca_nxt;
    out_cb_r <= out_cb_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cipher_a    = out_ca_r;
  assign out_ch.cipher_b    = out_cb_r;
  assign out_ch.square_full = out_full_r;

`ifndef NO_ASSERTIONS
  // Fill count never passes the cell count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SQ_CELLS)
    else $error("fill count beyond square size");

  // Used letters and filled cells stay in step
  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(fill_r))
    else $error("used letters disagree with fill count");

  // An append grows the square by exactly one cell
  a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
    ap_ok |=> fill_r == $past(fill_r) + 5'd1)
    else $error("append did not advance fill count");

  // A nonzero cipher letter only comes from a full square
  a_cipher_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_ca_r != 5'd0) || (out_cb_r != 5'd0))) |-> out_full_r)
    else $error("cipher letters without a full square");

  // The square is only searched when full
  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (fill_r == SQ_CELLS))
    else $error("search started on a partial square");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for playfair_digram_cipher_core: builds key squares, encrypts pairs
// and compares every result item against a cycle-free prediction of the square.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if and the core with its RAM.
module testbench;
  import pfc_pkg::*;

  typedef struct packed {
    letter_t cipher_a;
    letter_t cipher_b;
    logic    square_full;
  } cipher_res_t;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst_n;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  playfair_digram_cipher_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted square contents
  letter_t sq_cell [CELLS_N];
  bit      letter_seen [ALPHA_N];
  int      cells_filled;

  cipher_res_t cipher_due_q [$];

  bit quiet;
  int errors;
  int items_sent;
  int results_checked;
  int pairs_keyed;
  int sessions_run;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Fold j onto i
  function automatic letter_t as_i(letter_t c);
    return (c == CODE_J) ? CODE_I : c;
  endfunction

  // Append one letter to the predicted square if it is new and fits
  function automatic void add_letter(letter_t c);
    if (c >= ALPHA || cells_filled >= CELLS_N || letter_seen[c])
      return;
    sq_cell[cells_filled] = c;
    letter_seen[c] = 1'b1;
    cells_filled++;
  endfunction

  // Cell index of a letter, CELLS_N when absent
  function automatic int find_cell(letter_t c);
    for (int k = 0; k < CELLS_N; k++)
      if (sq_cell[k] == c)
        return k;
    return CELLS_N;
  endfunction

  // Update the predicted square for one item and return its result item
  function automatic cipher_res_t cipher_item(opcode_t op, letter_t a, letter_t b);
    cipher_res_t r;
    int p1, p2, r1, r2, c1, c2, q1, q2;
    r = '0;
    case (op)
      OP_CLEAR: begin
        foreach (letter_seen[k]) letter_seen[k] = 1'b0;
        cells_filled = 0;
      end
      OP_KEY: begin
        add_letter(as_i(a));
      end
      OP_FINISH: begin
        for (int c = 0; c < ALPHA_N; c++)
          if (letter_t'(c) != CODE_J)
            add_letter(letter_t'(c));
      end
      default: begin
        if (cells_filled == CELLS_N && a < ALPHA && b < ALPHA) begin
          p1 = find_cell(as_i(a));
          p2 = find_cell(as_i(b));
          if (p1 < CELLS_N && p2 < CELLS_N) begin
            r1 = p1 / 5; c1 = p1 % 5;
            r2 = p2 / 5; c2 = p2 % 5;
            if (r1 == r2) begin
              q1 = r1 * 5 + (c1 + 1) % 5;
              q2 = r2 * 5 + (c2 + 1) % 5;
            end else if (c1 == c2) begin
              q1 = ((r1 + 1) % 5) * 5 + c1;
              q2 = ((r2 + 1) % 5) * 5 + c2;
            end else begin
              q1 = r1 * 5 + c2;
              q2 = r2 * 5 + c1;
            end
            r.cipher_a = sq_cell[q1];
            r.cipher_b = sq_cell[q2];
            pairs_keyed++;
          end
        end
      end
    endcase
    r.square_full = (cells_filled == CELLS_N);
    return r;
  endfunction

  // Any 5-bit code
  function automatic letter_t any_code();
    return letter_t'($urandom_range(0, 31));
  endfunction

  // Mostly a real letter, now and then a code past z
  function automatic letter_t pair_letter();
    if ($urandom_range(0, 15) == 0)
      return letter_t'($urandom_range(26, 31));
    return letter_t'($urandom_range(0, 25));
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    errors++;
    $display("[%0t] mismatch: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // Send one item, idling first at random; leave valid high afterwards
  task automatic send_item(opcode_t op, letter_t a, letter_t b);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.letter_a <= a;
    in_ch.letter_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    cipher_due_q.push_back(cipher_item(op, a, b));
    items_sent++;
  endtask

  // Hold off the sender until every expected result item is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cipher_due_q.size() != 0);
  endtask

  // Known keyword square, every pair rule, the odd codes and the not-full cases
  task automatic test_directed();
    letter_t kw [12] = '{5'd15, 5'd11, 5'd0, 5'd24, 5'd5, 5'd8, 5'd17, 5'd4, 5'd23,
                         5'd12, 5'd9, 5'd31};
    // encrypt on an empty square
    send_item(OP_PAIR, 5'd0, 5'd25);
    // keyword with a repeat folded from j and a code past z
    foreach (kw[k]) send_item(OP_KEY, kw[k], any_code());
    // encrypt on a partial square
    send_item(OP_PAIR, 5'd15, 5'd11);
    send_item(OP_FINISH, 5'd0, 5'd0);
    send_item(OP_FINISH, 5'd31, 5'd31);
    send_item(OP_KEY, 5'd25, 5'd0);
    // same row, same column, rectangle
    send_item(OP_PAIR, 5'd15, 5'd5);
    send_item(OP_PAIR, 5'd11, 5'd2);
    send_item(OP_PAIR, 5'd7, 5'd8);
    send_item(OP_PAIR, 5'd24, 5'd19);
    // equal letters, j in a pair, codes past z, alphabet ends
    send_item(OP_PAIR, 5'd0, 5'd0);
    send_item(OP_PAIR, 5'd9, 5'd23);
    send_item(OP_PAIR, 5'd26, 5'd3);
    send_item(OP_PAIR, 5'd0, 5'd31);
    send_item(OP_PAIR, 5'd25, 5'd0);
    // clear drops the square
    send_item(OP_CLEAR, 5'd31, 5'd31);
    send_item(OP_PAIR, 5'd4, 5'd8);
  endtask

  // One well-formed session: clear, build a square, encrypt a run of pairs
  task automatic run_session();
    letter_t perm [CELLS_N];
    letter_t t;
    int n, j;
    send_item(OP_CLEAR, any_code(), any_code());
    if ($urandom_range(0, 7) == 0) begin
      // fill the whole square from key letters, shuffled
      n = 0;
      for (int c = 0; c < ALPHA_N; c++)
        if (letter_t'(c) != CODE_J) begin
          perm[n] = letter_t'(c);
          n++;
        end
      for (int k = CELLS_N - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = perm[k]; perm[k] = perm[j]; perm[j] = t;
      end
      foreach (perm[k])
        send_item(OP_KEY, (perm[k] == CODE_I && $urandom_range(0, 1)) ? CODE_J : perm[k],
                  any_code());
    end else begin
      n = $urandom_range(0, 14);
      repeat (n) send_item(OP_KEY, pair_letter(), any_code());
      if ($urandom_range(0, 3) == 0)
        send_item(OP_PAIR, pair_letter(), pair_letter());
      send_item(OP_FINISH, any_code(), any_code());
    end
    n = $urandom_range(20, 50);
    repeat (n) begin
      if ($urandom_range(0, 11) == 0)
        send_item(opcode_t'($urandom_range(0, 3)), any_code(), any_code());
      else
        send_item(OP_PAIR, pair_letter(), pair_letter());
    end
    sessions_run++;
    if ($urandom_range(0, 4) == 0)
      wait_drained();
  endtask

  task automatic test_random_sessions(int count);
    repeat (count) run_session();
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_no_idle(int count);
    quiet = 1'b1;
    repeat (count) run_session();
    quiet = 1'b0;
  endtask

  // Fully random items
  task automatic test_noise(int count);
    repeat (count) send_item(opcode_t'($urandom_range(0, 3)), any_code(), any_code());
  endtask

  // Result side: check accepted result items, stall at random
  initial begin
    cipher_res_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (cipher_due_q.size() == 0) begin
          report_mismatch("result item with nothing expected, square_full", 0,
                          int'(out_ch.square_full));
        end else begin
          want = cipher_due_q.pop_front();
          if (out_ch.cipher_a !== want.cipher_a)
            report_mismatch("cipher_a", int'(want.cipher_a), int'(out_ch.cipher_a));
          if (out_ch.cipher_b !== want.cipher_b)
            report_mismatch("cipher_b", int'(want.cipher_b), int'(out_ch.cipher_b));
          if (out_ch.square_full !== want.square_full)
            report_mismatch("square_full", int'(want.square_full),
                            int'(out_ch.square_full));
          results_checked++;
        end
      end
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 11);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
          stall = 0;
        else
          stall++;
        if (stall >= STALL_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_CLEAR;
    in_ch.letter_a = '0;
    in_ch.letter_b = '0;
    quiet          = 1'b0;
    errors         = 0;
    foreach (letter_seen[k]) letter_seen[k] = 1'b0;
    foreach (sq_cell[k]) sq_cell[k] = '0;
    cells_filled = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_drained();
    test_random_sessions(28);
    wait_drained();
    test_no_idle(6);
    test_noise(200);

    // Drain and let the pipeline settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cipher_due_q.size() != 0)
      report_mismatch("result items never delivered", 0, cipher_due_q.size());

    $display("covered %0d items in %0d key sessions plus directed and random traffic",
             items_sent, sessions_run);
    $display("checked %0d result items, %0d pairs enciphered on a full square, %0d mismatches",
             results_checked, pairs_keyed, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: playfair_digram_cipher_core.f
sv/pfc_pkg.sv
sv/pfc_in_if.sv
sv/pfc_out_if.sv
sv/pfc_ram.sv
sv/playfair_digram_cipher_core.sv
verif/testbench.sv
